// ===== src/module_link_health_supervisor_macros.svh =====
// ----------------------------------------------------------------------------
// link health supervisor assertion macros
// implication checks under a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef MODULE_LINK_HEALTH_SUPERVISOR_MACROS_SVH
`define MODULE_LINK_HEALTH_SUPERVISOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lhs assertion failed");
// next-cycle implication
`define LHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lhs assertion failed");
`else
`define LHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/lhs_pkg.sv =====
// ----------------------------------------------------------------------------
// lhs_pkg
// shared types, constants and event code helpers of the link health supervisor
// ----------------------------------------------------------------------------
`default_nettype none

package lhs_pkg;

    localparam int NMOD           = 3;
    localparam int MAX_RES        = 5;
    localparam int RES_CNT_W      = $clog2(MAX_RES + 1);
    localparam int EV_SLOTS       = 8;
    localparam int COUNT_BITS_DEF = 4;
    localparam int CONFIRM_W      = 4;
    localparam int TIME_W         = 32;
    localparam int MS_W           = 16;
    localparam int SEQ_W          = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [MS_W-1:0]      PERIOD_RST  = 16'd200;
    localparam logic [CONFIRM_W-1:0] OFFLINE_RST = 4'd5;
    localparam logic [CONFIRM_W-1:0] RECOVER_RST = 4'd3;
    localparam logic [MS_W-1:0]      STALE_RST   = 16'd1000;

    typedef enum logic [1:0] {
        CFG_PERIOD  = 2'd0,
        CFG_OFFLINE = 2'd1,
        CFG_RECOVER = 2'd2,
        CFG_STALE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_OFF_DATA    = 4'd1,
        EV_OFF_SENSOR  = 4'd2,
        EV_OFF_GIMBAL  = 4'd3,
        EV_REC_DATA    = 4'd4,
        EV_REC_SENSOR  = 4'd5,
        EV_REC_GIMBAL  = 4'd6,
        EV_NRDY_DATA   = 4'd7,
        EV_NRDY_SENSOR = 4'd8,
        EV_NRDY_GIMBAL = 4'd9,
        EV_STALE       = 4'd10,
        EV_GIMBAL_ERR  = 4'd11
    } t_event_code;

    typedef enum logic [1:0] {
        MOD_DATA   = 2'd0,
        MOD_SENSOR = 2'd1,
        MOD_GIMBAL = 2'd2
    } t_mod_id;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [NMOD-1:0]   responding_mask;
        logic [NMOD-1:0]   module_ready_mask;
        logic              data_delivered;
        logic              gimbal_fault;
    } t_in_word;

    typedef struct packed {
        logic [3:0]       event_code;
        logic             evaluated;
        logic [NMOD-1:0]  online_flags;
        logic [NMOD-1:0]  ready_flags;
        logic             data_fresh;
        logic             gimbal_error_flag;
        logic [SEQ_W-1:0] data_sequence;
        logic             last;
    } t_out_word;

    typedef struct packed {
        logic             evaluated;
        logic [NMOD-1:0]  online_flags;
        logic [NMOD-1:0]  ready_flags;
        logic             data_fresh;
        logic             gimbal_error_flag;
        logic [SEQ_W-1:0] data_sequence;
    } t_status;

    // one evaluation: up to five codes, padded with EV_NONE, and the word count
    typedef struct packed {
        t_event_code [MAX_RES-1:0] codes;
        logic [RES_CNT_W-1:0]      n_res;
        t_status                   status;
    } t_rec;

    function automatic t_event_code ev_offline(input t_mod_id m);
        t_event_code c;
        unique case (m)
            MOD_DATA:   c = EV_OFF_DATA;
            MOD_SENSOR: c = EV_OFF_SENSOR;
            MOD_GIMBAL: c = EV_OFF_GIMBAL;
            default:    c = EV_NONE;
        endcase
        return c;
    endfunction

    function automatic t_event_code ev_recover(input t_mod_id m);
        t_event_code c;
        unique case (m)
            MOD_DATA:   c = EV_REC_DATA;
            MOD_SENSOR: c = EV_REC_SENSOR;
            MOD_GIMBAL: c = EV_REC_GIMBAL;
            default:    c = EV_NONE;
        endcase
        return c;
    endfunction

    function automatic t_event_code ev_notready(input t_mod_id m);
        t_event_code c;
        unique case (m)
            MOD_DATA:   c = EV_NRDY_DATA;
            MOD_SENSOR: c = EV_NRDY_SENSOR;
            MOD_GIMBAL: c = EV_NRDY_GIMBAL;
            default:    c = EV_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/module_link_health_supervisor.sv =====
// ----------------------------------------------------------------------------
// module_link_health_supervisor
// link, readiness, data freshness and gimbal error supervision of three modules
// ----------------------------------------------------------------------------
// usage
//  input channel i_in_valid/o_in_ready carries one time sample per word; the
//  output channel o_out_valid/i_out_ready carries result words, the final word
//  of each sample marked by last
//  a sample is evaluated in the cycle it is accepted; its record passes through
//  the queue and then the output register, which sends its words after those
//  of any sample queued ahead of it
//  a skipped sample gives one word, an evaluated one gives one to five words,
//  sent at one word per cycle while the receiver takes them from the output
//  register; a two-entry queue lets new samples in while words drain
//  configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle
//  reset clears all supervision state, empties the queue and loads the
//  default period, confirm counts and stale timeout
//  when the receiver stalls the output word holds; once the queue fills,
//  o_in_ready drops until the oldest sample's last word enters the output
//  register
// ----------------------------------------------------------------------------
`default_nettype none

module module_link_health_supervisor #(
    parameter int COUNT_BITS  = lhs_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = lhs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire lhs_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [lhs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire lhs_pkg::t_in_word              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output lhs_pkg::t_out_word                  o_out_data
);

    localparam int RW = $bits(lhs_pkg::t_rec);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    lhs_pkg::t_rec w_rec;
    lhs_pkg::t_rec w_head;
    logic [RW-1:0] w_head_bits;

    lhs_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_rec      (w_rec)
    );

    lhs_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_rec),
        .i_pop   (w_pop),
        .o_head  (w_head_bits),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign w_head = lhs_pkg::t_rec'(w_head_bits);

    lhs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== src/lhs_fifo.sv =====
// ----------------------------------------------------------------------------
// lhs_fifo
// short register queue between the evaluation front and the word serialiser
// ----------------------------------------------------------------------------
`default_nettype none
`include "module_link_health_supervisor_macros.svh"

module lhs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_head,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `LHS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop)
    `LHS_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_empty)

endmodule

`default_nettype wire

// ===== src/lhs_front.sv =====
// ----------------------------------------------------------------------------
// lhs_front
// configuration registers, period gate and combinational evaluation of an accepted sample
// ----------------------------------------------------------------------------
`default_nettype none
`include "module_link_health_supervisor_macros.svh"

module lhs_front #(
    parameter int COUNT_BITS = lhs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire lhs_pkg::t_cfg_idx               i_cfg_idx,
    input  wire logic [lhs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    input  wire lhs_pkg::t_in_word               i_in_data,
    output logic                                 o_in_ready,
    input  wire logic                            i_q_full,
    output logic                                 o_push,
    output lhs_pkg::t_rec                        o_rec
);

    localparam int NMOD = lhs_pkg::NMOD;
    localparam int CW   = (COUNT_BITS > lhs_pkg::CONFIRM_W) ? COUNT_BITS
                                                            : lhs_pkg::CONFIRM_W;
    localparam int TW   = lhs_pkg::TIME_W;

    typedef logic [COUNT_BITS-1:0] t_cnt;

    // configuration
    logic [lhs_pkg::MS_W-1:0]      r_period;
    logic [lhs_pkg::CONFIRM_W-1:0] r_offline_cf;
    logic [lhs_pkg::CONFIRM_W-1:0] r_recover_cf;
    logic [lhs_pkg::MS_W-1:0]      r_stale;

    // supervision state
    logic [TW-1:0]           r_last_eval, n_last_eval;
    logic [NMOD-1:0]         r_on, n_on;
    logic [NMOD-1:0]         r_offl, n_offl;
    logic [NMOD-1:0]         r_flt, n_flt;
    logic [NMOD-1:0]         r_rdy, n_rdy;
    t_cnt [NMOD-1:0]         r_succ, n_succ;
    t_cnt [NMOD-1:0]         r_miss, n_miss;
    t_cnt [NMOD-1:0]         r_nr, n_nr;
    t_cnt [NMOD-1:0]         r_rr, n_rr;
    logic [TW-1:0]           r_ldt, n_ldt;
    t_cnt                    r_fcnt, n_fcnt;
    logic                    r_fresh, n_fresh;
    logic                    r_stale_l, n_stale_l;
    logic                    r_gerr, n_gerr;
    t_cnt                    r_grc, n_grc;
    logic [lhs_pkg::SEQ_W-1:0] r_seq, n_seq;

    logic                                        w_accept;
    logic                                        w_due;
    logic [lhs_pkg::EV_SLOTS-1:0]                w_ev_v;
    lhs_pkg::t_event_code [lhs_pkg::EV_SLOTS-1:0] w_ev_c;
    lhs_pkg::t_event_code [lhs_pkg::MAX_RES-1:0]  w_list;
    logic [lhs_pkg::RES_CNT_W-1:0]               w_cnt;

    // saturating increment, limited by the confirm value and the counter width
    function automatic t_cnt bump(input t_cnt c, input logic [lhs_pkg::CONFIRM_W-1:0] lim);
        return (CW'(c) < CW'(lim) && c != '1) ? c + t_cnt'(1) : c;
    endfunction

    function automatic logic reached(input t_cnt c,
                                     input logic [lhs_pkg::CONFIRM_W-1:0] lim);
        return CW'(c) >= CW'(lim);
    endfunction

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign o_push     = w_accept;
    assign w_due      = (i_in_data.now_ms - r_last_eval) >= TW'(r_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= lhs_pkg::PERIOD_RST;
            r_offline_cf <= lhs_pkg::OFFLINE_RST;
            r_recover_cf <= lhs_pkg::RECOVER_RST;
            r_stale      <= lhs_pkg::STALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lhs_pkg::CFG_PERIOD:  r_period     <= i_cfg_data;
                lhs_pkg::CFG_OFFLINE: r_offline_cf <= i_cfg_data[lhs_pkg::CONFIRM_W-1:0];
                lhs_pkg::CFG_RECOVER: r_recover_cf <= i_cfg_data[lhs_pkg::CONFIRM_W-1:0];
                lhs_pkg::CFG_STALE:   r_stale      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_last_eval = r_last_eval;
        n_on        = r_on;
        n_offl      = r_offl;
        n_flt       = r_flt;
        n_rdy       = r_rdy;
        n_succ      = r_succ;
        n_miss      = r_miss;
        n_nr        = r_nr;
        n_rr        = r_rr;
        n_ldt       = r_ldt;
        n_fcnt      = r_fcnt;
        n_fresh     = r_fresh;
        n_stale_l   = r_stale_l;
        n_gerr      = r_gerr;
        n_grc       = r_grc;
        n_seq       = r_seq;
        w_ev_v      = '0;
        w_ev_c      = {lhs_pkg::EV_SLOTS{lhs_pkg::EV_NONE}};

        if (w_accept && w_due) begin
            n_last_eval = i_in_data.now_ms;

            // per module: two event slots, link transition then ready fault or its recovery
            for (int m = 0; m < NMOD; m++) begin
                if (i_in_data.responding_mask[m]) begin
                    n_miss[m] = '0;
                    n_succ[m] = bump(r_succ[m], r_recover_cf);
                    if (!r_on[m] && reached(n_succ[m], r_recover_cf)) begin
                        n_on[m] = 1'b1;
                        if (r_offl[m]) begin
                            n_offl[m]   = 1'b0;
                            w_ev_v[2*m] = 1'b1;
                            w_ev_c[2*m] = lhs_pkg::ev_recover(lhs_pkg::t_mod_id'(m));
                        end
                    end
                end else begin
                    n_succ[m] = '0;
                    n_miss[m] = bump(r_miss[m], r_offline_cf);
                    if (r_on[m] && reached(n_miss[m], r_offline_cf)) begin
                        n_on[m]     = 1'b0;
                        n_offl[m]   = 1'b1;
                        w_ev_v[2*m] = 1'b1;
                        w_ev_c[2*m] = lhs_pkg::ev_offline(lhs_pkg::t_mod_id'(m));
                    end
                end

                if (!n_on[m]) begin
                    n_nr[m] = '0;
                    n_rr[m] = '0;
                end else if (!i_in_data.module_ready_mask[m]) begin
                    n_rr[m] = '0;
                    n_nr[m] = bump(r_nr[m], r_recover_cf);
                    if (!r_flt[m] && reached(n_nr[m], r_recover_cf)) begin
                        n_flt[m]      = 1'b1;
                        w_ev_v[2*m+1] = 1'b1;
                        w_ev_c[2*m+1] = lhs_pkg::ev_notready(lhs_pkg::t_mod_id'(m));
                    end
                end else begin
                    n_nr[m] = '0;
                    if (r_flt[m]) begin
                        n_rr[m] = bump(r_rr[m], r_recover_cf);
                        if (reached(n_rr[m], r_recover_cf)) begin
                            n_flt[m]      = 1'b0;
                            n_rr[m]       = '0;
                            w_ev_v[2*m+1] = 1'b1;
                            w_ev_c[2*m+1] = lhs_pkg::ev_recover(lhs_pkg::t_mod_id'(m));
                        end
                    end
                end
                n_rdy[m] = n_on[m] && i_in_data.module_ready_mask[m] && !n_flt[m];
            end

            // data freshness, slot six
            if (!n_on[lhs_pkg::MOD_DATA]) begin
                n_fresh = 1'b0;
                n_fcnt  = '0;
            end else if (i_in_data.data_delivered) begin
                n_ldt = i_in_data.now_ms;
                n_seq = r_seq + lhs_pkg::SEQ_W'(1);
                if (!r_fresh) begin
                    n_fcnt = bump(r_fcnt, r_recover_cf);
                    if (reached(n_fcnt, r_recover_cf)) begin
                        n_fresh = 1'b1;
                        if (r_stale_l) begin
                            n_stale_l = 1'b0;
                            w_ev_v[6] = 1'b1;
                            w_ev_c[6] = lhs_pkg::EV_REC_DATA;
                        end
                    end
                end
            end else begin
                n_fcnt = '0;
                if (r_fresh && (i_in_data.now_ms - r_ldt) >= TW'(r_stale)) begin
                    n_fresh   = 1'b0;
                    n_stale_l = 1'b1;
                    w_ev_v[6] = 1'b1;
                    w_ev_c[6] = lhs_pkg::EV_STALE;
                end
            end

            // gimbal error latch, slot seven
            if (i_in_data.gimbal_fault) begin
                n_grc = '0;
                if (!r_gerr) begin
                    n_gerr    = 1'b1;
                    w_ev_v[7] = 1'b1;
                    w_ev_c[7] = lhs_pkg::EV_GIMBAL_ERR;
                end
            end else if (r_gerr && n_on[lhs_pkg::MOD_GIMBAL] && n_rdy[lhs_pkg::MOD_GIMBAL]) begin
                n_grc = bump(r_grc, r_recover_cf);
                if (reached(n_grc, r_recover_cf)) begin
                    n_gerr    = 1'b0;
                    w_ev_v[7] = 1'b1;
                    w_ev_c[7] = lhs_pkg::EV_REC_GIMBAL;
                end
            end
        end
    end

    // pack raised events in order, keeping the first five
    always_comb begin
        w_list = {lhs_pkg::MAX_RES{lhs_pkg::EV_NONE}};
        w_cnt  = '0;
        for (int s = 0; s < lhs_pkg::EV_SLOTS; s++) begin
            if (w_ev_v[s] && w_cnt < lhs_pkg::RES_CNT_W'(lhs_pkg::MAX_RES)) begin
                w_list[w_cnt] = w_ev_c[s];
                w_cnt         = w_cnt + lhs_pkg::RES_CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_rec.codes = w_list;
        o_rec.n_res = (w_cnt == lhs_pkg::RES_CNT_W'(lhs_pkg::MAX_RES)) ? w_cnt
                                                                     : w_cnt + 1'b1;
        o_rec.status.evaluated         = w_due;
        o_rec.status.online_flags      = n_on;
        o_rec.status.ready_flags       = n_rdy;
        o_rec.status.data_fresh        = n_fresh;
        o_rec.status.gimbal_error_flag = n_gerr;
        o_rec.status.data_sequence     = n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_eval <= '0;
            r_on        <= '0;
            r_offl      <= '0;
            r_flt       <= '0;
            r_rdy       <= '0;
            r_succ      <= '0;
            r_miss      <= '0;
            r_nr        <= '0;
            r_rr        <= '0;
            r_ldt       <= '0;
            r_fcnt      <= '0;
            r_fresh     <= 1'b0;
            r_stale_l   <= 1'b0;
            r_gerr      <= 1'b0;
            r_grc       <= '0;
            r_seq       <= '0;
        end else begin
            r_last_eval <= n_last_eval;
            r_on        <= n_on;
            r_offl      <= n_offl;
            r_flt       <= n_flt;
            r_rdy       <= n_rdy;
            r_succ      <= n_succ;
            r_miss      <= n_miss;
            r_nr        <= n_nr;
            r_rr        <= n_rr;
            r_ldt       <= n_ldt;
            r_fcnt      <= n_fcnt;
            r_fresh     <= n_fresh;
            r_stale_l   <= n_stale_l;
            r_gerr      <= n_gerr;
            r_grc       <= n_grc;
            r_seq       <= n_seq;
        end
    end

    `LHS_ASSERT_IMP(a_idle_single_word, i_clk, i_rst_n, o_push && !w_due, o_rec.n_res == 3'd1)
    `LHS_ASSERT_NXT(a_skip_keeps_time, i_clk, i_rst_n, o_push && !w_due, $stable(r_last_eval))

endmodule

`default_nettype wire

// ===== src/lhs_back.sv =====
// ----------------------------------------------------------------------------
// lhs_back
// serialises queued evaluations into result words through an output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "module_link_health_supervisor_macros.svh"

module lhs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lhs_pkg::t_rec i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lhs_pkg::t_out_word o_out_data
);

    logic [lhs_pkg::RES_CNT_W-1:0] r_idx, n_idx;
    logic                          r_valid, n_valid;
    lhs_pkg::t_out_word            r_word;
    lhs_pkg::t_out_word            w_word;
    logic                          w_load;
    logic                          w_final;

    assign w_final = (r_idx == i_head.n_res - 1'b1);
    // output register free or being taken, and an evaluation queued
    assign w_load  = (!r_valid || i_out_ready) && !i_empty;
    assign o_pop   = w_load && w_final;

    always_comb begin
        w_word.event_code        = i_head.codes[r_idx];
        w_word.evaluated         = i_head.status.evaluated;
        w_word.online_flags      = i_head.status.online_flags;
        w_word.ready_flags       = i_head.status.ready_flags;
        w_word.data_fresh        = i_head.status.data_fresh;
        w_word.gimbal_error_flag = i_head.status.gimbal_error_flag;
        w_word.data_sequence     = i_head.status.data_sequence;
        w_word.last              = w_final;
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
            n_idx   = w_final ? '0 : r_idx + 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= w_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;

    `LHS_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, !i_empty, r_idx < i_head.n_res)
    `LHS_ASSERT_NXT(a_pop_restarts, i_clk, i_rst_n, o_pop, r_idx == '0)

endmodule

`default_nettype wire
